>>> src/additive_harmonic_voice_unit_assert.svh
// assertion macros for the additive harmonic voice unit checker
// expects clk and rst in the scope where the macros are used
`ifndef ADDITIVE_HARMONIC_VOICE_UNIT_ASSERT_SVH
`define ADDITIVE_HARMONIC_VOICE_UNIT_ASSERT_SVH

// same-cycle implication
`define AHV_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AHV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ahv_pkg.sv
// shared types, constants and small tables for the additive harmonic voice unit
// no dependencies
package ahv_pkg;

  localparam int DEF_PHASE_BITS     = 24;
  localparam int DEF_SINE_ADDR_BITS = 10;
  localparam int DEF_AGE_BITS       = 24;

  localparam int CNT_W      = 24;
  localparam int INC_W      = 24;
  localparam int LEN_W      = 24;
  localparam int COEF_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int SAMPLE_W   = 16;
  localparam int ENV_W      = 17;

  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 63;
  localparam int DIV_Q_W   = 17;

  localparam int POLY_W = 17;
  localparam int MIX_W  = 21;
  localparam int HARM_W = 5;
  localparam int PART_W = 2;

  localparam logic [PART_W-1:0] LAST_PART = PART_W'(3);
  localparam logic [PART_W-1:0] LAST_STEP = PART_W'(3);

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_LEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_COEF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 3'd4;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_NOTE_ON = 1'b1;

  localparam logic [ENV_W-1:0] ENV_FULL = ENV_W'(65536);
  localparam logic [POLY_W-1:0] POLY_C9 = POLY_W'(11);

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [HARM_W-1:0] harm_mult(input logic [PART_W-1:0] k);
    logic [HARM_W-1:0] h;
    case (k)
      2'd0:    h = 5'd7;
      2'd1:    h = 5'd11;
      2'd2:    h = 5'd13;
      default: h = 5'd19;
    endcase
    return h;
  endfunction

  // sine polynomial coefficients, Q16, innermost first after c9
  function automatic logic [POLY_W-1:0] poly_coef(input logic [PART_W-1:0] k);
    logic [POLY_W-1:0] c;
    case (k)
      2'd0:    c = 17'd307;
      2'd1:    c = 17'd5223;
      2'd2:    c = 17'd42334;
      default: c = 17'd102944;
    endcase
    return c;
  endfunction

endpackage

>>> src/additive_harmonic_voice_unit.sv
// One-voice additive synthesiser: each sample tick returns one 16-bit sample built from four
// sine partials (7, 11, 13 and 19 times the base increment, weighted 1, 1/2, 1/4, 1/8) under an
// attack / decay / release envelope and an output gain; a note-on transaction restarts the
// envelope and returns nothing. All arithmetic runs through one registered 32x32 multiplier and
// one bit-serial divider under a sequencer, and in_ready is low while a tick is in progress. A
// tick holds the block through the phase and sine polynomial steps (one product per cycle)
// and the envelope divisions (17 quotient bits each); a tick during release needs a second
// division. A finished sample waits in the output register while the next transaction is taken.
// Configuration registers are written through cfg_wen / cfg_index / cfg_data; the user must
// write them only while idle, as the block itself does not enforce this.
// depends on ahv_pkg, ahv_mul, ahv_div
module additive_harmonic_voice_unit import ahv_pkg::*; #(
  parameter int PHASE_BITS     = DEF_PHASE_BITS,
  parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS,
  parameter int AGE_BITS       = DEF_AGE_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       op,
  input  logic [INC_W-1:0]           phase_inc,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic [ENV_W-1:0]           env_level,
  input  logic                       cfg_wen,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int QUAD_BITS = SINE_ADDR_BITS - 2;
  localparam int U_PAD     = 16 - QUAD_BITS;
  localparam int CMP_W     = (AGE_BITS > LEN_W) ? AGE_BITS : LEN_W;
  localparam int Q_SHIFT   = 16;
  localparam int SIN_LO    = 17;
  localparam int X_LIM_BIT = 31;
  localparam int RND_LO    = 34;
  localparam int RND_W     = 18;
  localparam int ST_W      = 5;

  localparam logic [POLY_W-1:0] U_ONE    = POLY_W'(65536);
  localparam logic [POLY_W-1:0] SINE_MAX = POLY_W'(32767);
  localparam logic [RND_W-1:0]  MAG_POS  = RND_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic [RND_W-1:0]  MAG_NEG  = RND_W'(2 ** (SAMPLE_W - 1));

  localparam logic [ST_W-1:0] ST_IDLE    = 5'd0;
  localparam logic [ST_W-1:0] ST_BASE    = 5'd1;
  localparam logic [ST_W-1:0] ST_BASE_W  = 5'd2;
  localparam logic [ST_W-1:0] ST_PHASE   = 5'd3;
  localparam logic [ST_W-1:0] ST_SQ      = 5'd4;
  localparam logic [ST_W-1:0] ST_U2      = 5'd5;
  localparam logic [ST_W-1:0] ST_POLY    = 5'd6;
  localparam logic [ST_W-1:0] ST_SINE    = 5'd7;
  localparam logic [ST_W-1:0] ST_ENV     = 5'd8;
  localparam logic [ST_W-1:0] ST_DECAY   = 5'd9;
  localparam logic [ST_W-1:0] ST_SQR     = 5'd10;
  localparam logic [ST_W-1:0] ST_DIVIDE  = 5'd11;
  localparam logic [ST_W-1:0] ST_REL     = 5'd12;
  localparam logic [ST_W-1:0] ST_REL_MUL = 5'd13;
  localparam logic [ST_W-1:0] ST_GAIN    = 5'd14;
  localparam logic [ST_W-1:0] ST_MIX     = 5'd15;
  localparam logic [ST_W-1:0] ST_ROUND   = 5'd16;
  localparam logic [ST_W-1:0] ST_DONE    = 5'd17;

  logic [ST_W-1:0] state;
  logic [ST_W-1:0] state_next;

  logic [LEN_W-1:0]  attack_len;
  logic [LEN_W-1:0]  hold_len;
  logic [LEN_W-1:0]  release_len;
  logic [COEF_W-1:0] decay_coef;
  logic [COEF_W-1:0] output_gain;

  logic [CNT_W-1:0]      sample_count;
  logic [AGE_BITS-1:0]   age;
  logic [INC_W-1:0]      inc;
  logic [PHASE_BITS-1:0] base;
  logic [POLY_W-1:0]     u;
  logic [POLY_W-1:0]     u2;
  logic [1:0]            quad;
  logic [PART_W-1:0]     part;
  logic [PART_W-1:0]     step;
  logic signed [MIX_W-1:0] acc;
  logic [ENV_W-1:0]      env;
  logic                  rel_phase;
  logic [SAMPLE_W-1:0]   res_sample;

  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic [PHASE_BITS-1:0]     phase;
  logic [SINE_ADDR_BITS-1:0] addr;
  logic [POLY_W-1:0]         u_raw;
  logic [POLY_W-1:0]         u_mir;
  logic [POLY_W-1:0]         prod_hi;
  logic [POLY_W-1:0]         coef_r;
  logic [POLY_W-1:0]         s_full;
  logic [SAMPLE_W-2:0]       s_mag;
  logic signed [MIX_W-1:0]   s_sgn;
  logic [PART_W-1:0]         wsh;
  logic [MIX_W-1:0]          acc_mag;
  logic [CMP_W-1:0]          age_ext;
  logic [CMP_W-1:0]          hold_ext;
  logic [CMP_W-1:0]          rel_ext;
  logic [CMP_W-1:0]          r_ext;
  logic                      in_attack;
  logic [AGE_BITS-1:0]       t;
  logic                      releasing;
  logic                      rel_kill;
  logic [LEN_W-1:0]          rel_left;
  logic                      x_big;
  logic [RND_W-1:0]          rnd_mag;
  logic [SAMPLE_W-1:0]       sat_val;
  logic                      out_free;

  ahv_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  ahv_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // phase and sine address
  assign phase   = base * PHASE_BITS'(harm_mult(part));
  assign addr    = phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign u_raw   = {1'b0, addr[QUAD_BITS-1:0], {U_PAD{1'b0}}};
  assign u_mir   = addr[QUAD_BITS] ? (U_ONE - u_raw) : u_raw;
  assign prod_hi = prod[Q_SHIFT +: POLY_W];
  assign coef_r  = poly_coef(step) - prod_hi;

  // sine result and weighted mix
  assign s_full = prod[SIN_LO +: POLY_W];
  assign s_mag  = (s_full > SINE_MAX) ? SINE_MAX[SAMPLE_W-2:0] : s_full[SAMPLE_W-2:0];
  assign s_sgn  = quad[1] ? -$signed(MIX_W'(s_mag)) : $signed(MIX_W'(s_mag));
  assign wsh    = LAST_PART - part;
  assign acc_mag = acc[MIX_W-1] ? MIX_W'(-acc) : MIX_W'(acc);

  // envelope decisions
  assign age_ext   = CMP_W'(age);
  assign hold_ext  = CMP_W'(hold_len);
  assign rel_ext   = CMP_W'(release_len);
  assign r_ext     = age_ext - hold_ext;
  assign in_attack = age_ext < CMP_W'(attack_len);
  assign t         = AGE_BITS'(age_ext - CMP_W'(attack_len));
  assign releasing = (hold_len != '0) && (age_ext >= hold_ext);
  assign rel_kill  = (release_len == '0) || (r_ext > rel_ext);
  assign rel_left  = LEN_W'(rel_ext - r_ext);
  assign x_big     = |prod[PROD_W-1:X_LIM_BIT];

  // round half away from zero, then saturate
  assign rnd_mag = RND_W'(prod[PROD_W-1:RND_LO]) + RND_W'(prod[RND_LO-1]);
  always_comb begin
    if (acc[MIX_W-1]) begin
      sat_val = (rnd_mag >= MAG_NEG) ? SAMPLE_W'(MAG_NEG) : SAMPLE_W'(RND_W'(0) - rnd_mag);
    end else begin
      sat_val = (rnd_mag >= MAG_POS) ? SAMPLE_W'(MAG_POS) : SAMPLE_W'(rnd_mag);
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_BASE: begin
        mul_a = MUL_W'(sample_count);
        mul_b = MUL_W'(inc);
      end
      ST_SQ: begin
        mul_a = MUL_W'(u);
        mul_b = MUL_W'(u);
      end
      ST_U2: begin
        mul_a = MUL_W'(POLY_C9);
        mul_b = MUL_W'(prod_hi);
      end
      ST_POLY: begin
        mul_a = MUL_W'(coef_r);
        mul_b = (step == LAST_STEP) ? MUL_W'(u) : MUL_W'(u2);
      end
      ST_ENV: begin
        mul_a = MUL_W'(t);
        mul_b = MUL_W'(decay_coef);
      end
      ST_DECAY: begin
        mul_a = MUL_W'(prod[X_LIM_BIT-1:0]);
        mul_b = MUL_W'(prod[X_LIM_BIT-1:0]);
      end
      ST_REL: begin
        mul_a = MUL_W'(env);
        mul_b = MUL_W'(rel_left);
      end
      ST_GAIN: begin
        mul_a = MUL_W'(env);
        mul_b = MUL_W'(output_gain);
      end
      ST_MIX: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = MUL_W'(acc_mag);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_req = '0;
    unique case (state)
      ST_ENV: begin
        div_req.start = in_attack;
        div_req.num   = DIV_NUM_W'(age) << 16;
        div_req.den   = DIV_DEN_W'(attack_len);
      end
      ST_SQR: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'(1) << 48;
        div_req.den   = prod[DIV_DEN_W-1:0] + (DIV_DEN_W'(1) << 32);
      end
      ST_REL_MUL: begin
        div_req.start = 1'b1;
        div_req.num   = prod;
        div_req.den   = DIV_DEN_W'(release_len);
      end
      default: div_req = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid && op == OP_TICK) state_next = ST_BASE;
      ST_BASE:    state_next = ST_BASE_W;
      ST_BASE_W:  state_next = ST_PHASE;
      ST_PHASE:   state_next = ST_SQ;
      ST_SQ:      state_next = ST_U2;
      ST_U2:      state_next = ST_POLY;
      ST_POLY:    if (step == LAST_STEP) state_next = ST_SINE;
      ST_SINE:    state_next = (part == LAST_PART) ? ST_ENV : ST_PHASE;
      ST_ENV:     state_next = in_attack ? ST_DIVIDE : ST_DECAY;
      ST_DECAY:   state_next = x_big ? ST_REL : ST_SQR;
      ST_SQR:     state_next = ST_DIVIDE;
      ST_DIVIDE:  if (div_rsp.done) state_next = rel_phase ? ST_GAIN : ST_REL;
      ST_REL:     state_next = (releasing && !rel_kill) ? ST_REL_MUL : ST_GAIN;
      ST_REL_MUL: state_next = ST_DIVIDE;
      ST_GAIN:    state_next = ST_MIX;
      ST_MIX:     state_next = ST_ROUND;
      ST_ROUND:   state_next = ST_DONE;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      sample_count <= '0;
      age          <= '0;
      attack_len   <= LEN_W'(2646);
      hold_len     <= LEN_W'(44100);
      release_len  <= LEN_W'(22050);
      decay_coef   <= '0;
      output_gain  <= COEF_W'(13107);
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_ATTACK_LEN:  attack_len  <= cfg_data[LEN_W-1:0];
          REG_HOLD_LEN:    hold_len    <= cfg_data[LEN_W-1:0];
          REG_RELEASE_LEN: release_len <= cfg_data[LEN_W-1:0];
          REG_DECAY_COEF:  decay_coef  <= cfg_data[COEF_W-1:0];
          REG_OUTPUT_GAIN: output_gain <= cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end
      if (state == ST_IDLE && in_valid && op == OP_NOTE_ON) begin
        age <= '0;
      end
      if (state == ST_DONE && out_free) begin
        out_valid    <= 1'b1;
        sample_count <= sample_count + CNT_W'(1);
        if (age != '1) begin
          age <= age + AGE_BITS'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        inc       <= phase_inc;
        part      <= '0;
        acc       <= '0;
        rel_phase <= 1'b0;
      end
      ST_BASE_W: base <= prod[PHASE_BITS-1:0];
      ST_PHASE: begin
        u    <= u_mir;
        quad <= addr[SINE_ADDR_BITS-1 -: 2];
        step <= '0;
      end
      ST_U2:   u2 <= prod_hi;
      ST_POLY: step <= step + PART_W'(1);
      ST_SINE: begin
        acc  <= acc + (s_sgn <<< wsh);
        part <= part + PART_W'(1);
      end
      ST_DECAY:   if (x_big) env <= '0;
      ST_DIVIDE:  if (div_rsp.done) env <= div_rsp.quot;
      ST_REL:     if (releasing && rel_kill) env <= '0;
      ST_REL_MUL: rel_phase <= 1'b1;
      ST_ROUND:   res_sample <= sat_val;
      ST_DONE: begin
        if (out_free) begin
          sample    <= res_sample;
          env_level <= env;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> src/ahv_mul.sv
// shared multiplier with registered product
// depends on ahv_pkg
module ahv_mul import ahv_pkg::*; (
  input  logic              clk,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

>>> src/ahv_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on ahv_pkg; quotient must fit in DIV_Q_W bits
module ahv_div import ahv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(DIV_Q_W + 1);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_Q_W-1:0]   nq;
  logic [STEP_W-1:0]    cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  assign trial = {rem, nq[DIV_Q_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= STEP_W'(DIV_Q_W);
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= DIV_DEN_W'(req.num >> DIV_Q_W);
      nq  <= req.num[DIV_Q_W-1:0];
      den <= req.den;
    end else if (busy) begin
      rem <= fits ? DIV_DEN_W'(trial - {1'b0, den}) : trial[DIV_DEN_W-1:0];
      nq  <= {nq[DIV_Q_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = nq;

endmodule

>>> src/ahv_chk.sv
// port-level checker for the additive harmonic voice unit, bound to the top level
// depends on ahv_pkg and additive_harmonic_voice_unit_assert.svh
`include "additive_harmonic_voice_unit_assert.svh"

module ahv_chk import ahv_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                op,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] sample,
  input logic [ENV_W-1:0]    env_level
);

  `AHV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample) && $stable(env_level), "result changed while stalled")
  `AHV_ASSERT_NEXT(a_tick_busy, in_valid && in_ready && op == OP_TICK, !in_ready, "ready after tick transaction")
  `AHV_ASSERT_NEXT(a_note_silent, in_valid && in_ready && op == OP_NOTE_ON && !out_valid, !out_valid, "note on produced a result")
  `AHV_ASSERT_IMPL(a_zero_env, out_valid && env_level == '0, sample == '0, "non-zero sample with zero envelope")

endmodule

bind additive_harmonic_voice_unit ahv_chk u_ahv_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .op        (op),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .sample    (sample),
  .env_level (env_level)
);
